// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared types and codes of the double-ended queue
// Operation codes, status codes, field widths and the controller states.
// ----------------------------------------------------------------------------
package deq_pkg;

   // fixed field widths of the stream payload
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 32;

   // operation codes carried on req_tuser
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

   // status codes carried on rsp_tuser
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // controller states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_SEND = 3'b100
   } state_type;

endpackage

// File: rtl/core/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/double_ended_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded deque on a ring buffer RAM
// Push and query results are registered on the transfer; a pop that leaves two
// or more elements first passes ST_READ (RAM read of the new end element).
// Throughput: one push or query per cycle while rsp is not stalled; such a pop
// holds off new requests during the read of the single registered RAM port.
// Reset clears pointers, count, controller state and the response valid flag;
// the RAM and the payload registers are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_top import deq_pkg::*; #(
   parameter  int DEPTH       = 16,
   parameter  int DATA_WIDTH  = 32,
   localparam int CNT_W       = $clog2(DEPTH + 1),
   localparam int RSP_BITS    = 3 * VALUE_W + CNT_W + 1,
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [VALUE_W-1:0]     req_tdata,   // [31:0] value
   input  logic [FUNC_W-1:0]      req_tuser,   // [2:0] func
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // popped_value, front_value,
                                               // rear_value, occupancy,
                                               // empty flag, zero pad
   output logic [STATUS_W-1:0]    rsp_tuser    // [1:0] status
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                empty_flag;
      logic [CNT_W-1:0]    occupancy;
      logic [VALUE_W-1:0]  rear;
      logic [VALUE_W-1:0]  front;
      logic [VALUE_W-1:0]  popped;
   } res_type;

   // ring index step forward with wrap
   function automatic idx_type idx_next(input idx_type i);
      return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
   endfunction

   // ring index step backward with wrap
   function automatic idx_type idx_prev(input idx_type i);
      return (i == '0) ? IDX_LAST : i - IDX_W'(1);
   endfunction

   // sign-extend a stored element to the output field width
   function automatic logic [VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] x);
      logic [63:0] w;
      w = 64'($signed(x));
      return w[VALUE_W-1:0];
   endfunction

   // control state
   state_type             state_ff, state_in;
   idx_type               head_ff, head_in;
   idx_type               tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff;

   // cached end elements and pop bookkeeping
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] rear_ff, rear_in;
   logic [DATA_WIDTH-1:0] popped_ff, popped_in;
   logic                  take_head_ff, take_head_in;

   // output register and skid holding register
   res_type               rsp_ff;
   res_type               hold_ff;
   res_type               res_c;

   // RAM port signals
   logic                  wr_en;
   idx_type               wr_addr;
   logic                  rd_en;
   idx_type               rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [DATA_WIDTH-1:0] push_data;

   logic                  req_accept;
   logic                  out_free;
   logic                  load_c;
   logic [STATUS_W-1:0]   status_c;
   logic [DATA_WIDTH-1:0] popped_c;
   logic [FUNC_W-1:0]     func;

   assign func       = req_tuser;
   assign push_data  = DATA_WIDTH'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // element store
   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // decode the operation, update pointers and cached ends, steer the FSM
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      rear_in      = rear_ff;
      popped_in    = popped_ff;
      take_head_in = take_head_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      status_c     = STATUS_OK;
      popped_c     = '0;
      load_c       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               load_c = 1'b1;
               unique case (func) inside
                  FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                     if (count_ff == CNT_FULL) begin
                        status_c = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_ONE;
                        if (count_ff == '0) begin
                           head_in  = '0;
                           tail_in  = '0;
                           wr_addr  = '0;
                           front_in = push_data;
                           rear_in  = push_data;
                        end else if (func == FUNC_PUSH_FRONT) begin
                           head_in  = idx_prev(head_ff);
                           wr_addr  = head_in;
                           front_in = push_data;
                        end else begin
                           tail_in  = idx_next(tail_ff);
                           wr_addr  = tail_in;
                           rear_in  = push_data;
                        end
                     end
                  end
                  FUNC_POP_FRONT, FUNC_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_c = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_ONE;
                        if (func == FUNC_POP_FRONT) begin
                           popped_c = front_ff;
                           head_in  = idx_next(head_ff);
                           if (count_ff == CNT_TWO) begin
                              front_in = rear_ff;
                           end else if (count_ff > CNT_TWO) begin
                              // fetch the new front element
                              rd_en        = 1'b1;
                              rd_addr      = head_in;
                              popped_in    = front_ff;
                              take_head_in = 1'b1;
                              load_c       = 1'b0;
                              state_in     = ST_READ;
                           end
                        end else begin
                           popped_c = rear_ff;
                           tail_in  = idx_prev(tail_ff);
                           if (count_ff == CNT_TWO) begin
                              rear_in = front_ff;
                           end else if (count_ff > CNT_TWO) begin
                              // fetch the new rear element
                              rd_en        = 1'b1;
                              rd_addr      = tail_in;
                              popped_in    = rear_ff;
                              take_head_in = 1'b0;
                              load_c       = 1'b0;
                              state_in     = ST_READ;
                           end
                        end
                     end
                  end
                  default: begin
                     // query and unused codes leave the state alone
                  end
               endcase
            end
         end
         ST_READ: begin
            load_c   = 1'b1;
            popped_c = popped_ff;
            if (take_head_ff) begin
               front_in = rd_data;
            end else begin
               rear_in = rd_data;
            end
         end
         ST_SEND: begin
            // wait for the output register to drain
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // route a finished result to the output or the holding register
      if (load_c) begin
         state_in = out_free ? ST_IDLE : ST_SEND;
      end else if ((state_ff == ST_SEND) && out_free) begin
         state_in = ST_IDLE;
      end
   end

   // assemble the result from the post-operation state
   always_comb begin
      res_c.status     = status_c;
      res_c.popped     = to_out(popped_c);
      res_c.front      = (count_in != '0) ? to_out(front_in) : '0;
      res_c.rear       = (count_in != '0) ? to_out(rear_in) : '0;
      res_c.occupancy  = count_in;
      res_c.empty_flag = (count_in == '0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if ((load_c || (state_ff == ST_SEND)) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      front_ff     <= front_in;
      rear_ff      <= rear_in;
      popped_ff    <= popped_in;
      take_head_ff <= take_head_in;
      if (load_c && out_free) begin
         rsp_ff <= res_c;
      end else if ((state_ff == ST_SEND) && out_free) begin
         rsp_ff <= hold_ff;
      end
      if (load_c && !out_free) begin
         hold_ff <= res_c;
      end
   end

   // drive the response stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_ff.empty_flag, rsp_ff.occupancy, rsp_ff.rear,
                                     rsp_ff.front, rsp_ff.popped});

   // ring span between head and tail, for checking
   logic [IDX_W+1:0] span;
   assign span = (tail_ff >= head_ff)
               ? {2'b00, tail_ff} - {2'b00, head_ff} + (IDX_W+2)'(1)
               : {2'b00, tail_ff} - {2'b00, head_ff} + (IDX_W+2)'(DEPTH + 1);

   // the pointers always enclose exactly the stored elements
   a_span_matches_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (span == (IDX_W+2)'(count_ff)))
      else $error("head/tail span disagrees with element count");

   // a single element is both the front and the rear
   a_single_ends_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_ONE) |-> (front_ff == rear_ff))
      else $error("cached front and rear differ with one element");

   // the holding register is used only while the output register is full
   a_send_has_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> rsp_valid_ff)
      else $error("held result with empty output register");

   // the count never passes the depth
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("element count exceeds depth");

endmodule

// File: bench/double_ended_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb: self-checking bench for the bounded deque
// A driver sends push, pop and query operations on the request stream. A
// shadow deque predicts each response, and the monitor checks every response
// transfer against the oldest prediction. The run walks through phases of
// sender idling and receiver stalling. Random traffic mixes push-heavy,
// balanced and pop-heavy runs so the deque keeps filling up and draining.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb import deq_pkg::*; ();

   localparam int DEPTH        = 16;
   localparam int DATA_WIDTH   = 32;
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int RSP_W        = ((3 * VALUE_W + CNT_W + 1 + 7) / 8) * 8;
   localparam int OPS_PER_PASS = 406;
   localparam int MAX_REPORTED = 10;
   localparam int SETTLE_TIME  = 20;

   // func codes above the query code behave as a query
   localparam logic [FUNC_W-1:0] FUNC_LAST_CODE = '1;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
   } deque_op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  popped;
      logic [VALUE_W-1:0]  front;
      logic [VALUE_W-1:0]  rear;
      logic [CNT_W-1:0]    occupancy;
      logic                empty;
   } deque_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [VALUE_W-1:0]   req_tdata = '0;   // [31:0] value
   logic [FUNC_W-1:0]    req_tuser = '0;   // [2:0] func
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;        // popped, front, rear, occupancy, empty
   logic [STATUS_W-1:0]  rsp_tuser;        // [1:0] status

   deque_op_type     pending_ops[$];
   deque_result_type expected_results[$];
   logic             req_taken = 1'b0;
   int unsigned      send_idle_pct = 0;
   int unsigned      rsp_stall_pct = 0;
   int               error_count = 0;

   // shadow copy of the deque contents
   logic [VALUE_W-1:0] shadow_store [DEPTH];
   logic [IDX_W-1:0]   shadow_head = '0;
   logic [IDX_W-1:0]   shadow_tail = '0;
   logic [CNT_W-1:0]   shadow_count = '0;

   double_ended_queue_top #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // apply one operation to the shadow deque and return the response it implies
   function automatic deque_result_type predict_deque_op(input deque_op_type op);
      deque_result_type r;
      r = '0;
      r.status = STATUS_OK;
      case (op.func)
         FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
            if (shadow_count == CNT_W'(DEPTH)) begin
               r.status = STATUS_FULL;
            end else if (shadow_count == '0) begin
               shadow_head     = '0;
               shadow_tail     = '0;
               shadow_store[0] = op.value;
               shadow_count    = CNT_W'(1);
            end else if (op.func == FUNC_PUSH_FRONT) begin
               shadow_head = shadow_head - IDX_W'(1);
               shadow_store[shadow_head] = op.value;
               shadow_count = shadow_count + CNT_W'(1);
            end else begin
               shadow_tail = shadow_tail + IDX_W'(1);
               shadow_store[shadow_tail] = op.value;
               shadow_count = shadow_count + CNT_W'(1);
            end
         end
         FUNC_POP_FRONT, FUNC_POP_BACK: begin
            if (shadow_count == '0) begin
               r.status = STATUS_EMPTY;
            end else if (op.func == FUNC_POP_FRONT) begin
               r.popped     = shadow_store[shadow_head];
               shadow_head  = shadow_head + IDX_W'(1);
               shadow_count = shadow_count - CNT_W'(1);
            end else begin
               r.popped     = shadow_store[shadow_tail];
               shadow_tail  = shadow_tail - IDX_W'(1);
               shadow_count = shadow_count - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      if (shadow_count != '0) begin
         r.front = shadow_store[shadow_head];
         r.rear  = shadow_store[shadow_tail];
      end
      r.occupancy = shadow_count;
      r.empty     = (shadow_count == '0);
      return r;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTED) begin
         $display("%s", msg);
      end
   endtask

   // check response transfers, then predict the request transfer of this edge
   always @(posedge clock) begin
      deque_result_type got;
      deque_result_type want;
      deque_op_type     seen_op;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tuser;
            got.popped    = rsp_tdata[31:0];
            got.front     = rsp_tdata[63:32];
            got.rear      = rsp_tdata[95:64];
            got.occupancy = rsp_tdata[96 +: CNT_W];
            got.empty     = rsp_tdata[96 + CNT_W];
            if (expected_results.size() == 0) begin
               note_error($sformatf("%0t: response with nothing outstanding", $realtime));
            end else begin
               want = expected_results[0];
               expected_results.delete(0);
               if (got !== want) begin
                  note_error($sformatf({"%0t: response mismatch\n",
                     "  expected status %0d popped %h front %h rear %h count %0d empty %b\n",
                     "  actual   status %0d popped %h front %h rear %h count %0d empty %b"},
                     $realtime, want.status, want.popped, want.front, want.rear,
                     want.occupancy, want.empty, got.status, got.popped, got.front,
                     got.rear, got.occupancy, got.empty));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            seen_op.func  = req_tuser;
            seen_op.value = req_tdata;
            expected_results.insert(expected_results.size(), predict_deque_op(seen_op));
         end
         req_taken <= req_tvalid && req_tready;
      end
   end

   // advance the request stream and toggle the response ready
   always @(negedge clock) begin
      deque_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            op = pending_ops[0];
            pending_ops.delete(0);
            req_tvalid <= 1'b1;
            req_tdata  <= op.value;
            req_tuser  <= op.func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic queue_op(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
      deque_op_type op;
      op.func  = func;
      op.value = value;
      pending_ops.insert(pending_ops.size(), op);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // runs of push-heavy, balanced or pop-heavy traffic so the deque fills and drains
   task automatic queue_random_ops(input int count);
      int          added;
      int          run_len;
      int unsigned push_pct;
      int unsigned roll;
      added = 0;
      while (added < count) begin
         case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 50;
            default: push_pct = 15;
         endcase
         run_len = $urandom_range(8, 48);
         for (int k = 0; k < run_len && added < count; k++) begin
            roll = $urandom_range(99);
            if (roll < push_pct) begin
               queue_op($urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT, pick_value());
            end else if (roll < 96) begin
               queue_op($urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT, $urandom);
            end else begin
               queue_op(FUNC_W'($urandom_range(FUNC_QUERY, FUNC_LAST_CODE)), $urandom);
            end
            added++;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         shadow_store[i] = '0;
      end

      // pops on an empty deque, a spare func code, then the value extremes
      queue_op(FUNC_POP_FRONT, 32'h1234_5678);
      queue_op(FUNC_POP_BACK, 32'hffff_ffff);
      queue_op(FUNC_LAST_CODE, 32'h5555_aaaa);
      queue_op(FUNC_PUSH_BACK, 32'h7fff_ffff);
      queue_op(FUNC_PUSH_FRONT, 32'h8000_0000);
      queue_op(FUNC_POP_BACK, 32'h0);
      queue_op(FUNC_POP_FRONT, 32'h0);
      // fill from both ends so the head wraps, then push on a full deque
      for (int i = 0; i < DEPTH; i++) begin
         queue_op((i % 2) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, pick_value());
      end
      queue_op(FUNC_PUSH_FRONT, 32'hdead_beef);
      queue_op(FUNC_PUSH_BACK, 32'hcafe_f00d);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no idling, sender idle, receiver stalling, both
      for (int pass = 0; pass < 4; pass++) begin
         case (pass)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         queue_random_ops(OPS_PER_PASS);
         wait_drained();
      end

      repeat (SETTLE_TIME) @(posedge clock);
      if (expected_results.size() != 0) begin
         note_error($sformatf("%0d responses never arrived", expected_results.size()));
      end
      if (error_count == 0) begin
         $display("double_ended_queue_top_tb: clean");
      end else begin
         $display("double_ended_queue_top_tb: errors");
      end
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin
      #2_000_000;
      $display("double_ended_queue_top_tb: errors");
      $finish;
   end

endmodule
